// ===== sv/fba_pkg.sv =====
// fba_pkg: shared types, codes and helpers of the frame bitmap allocator
// depends on nothing; imported by fba_ctrl, fba_datapath and frame_bitmap_allocator
`default_nettype none

package fba_pkg;

   localparam int NUM_FRAMES_DEFAULT = 65536;
   localparam int RESERVED_DEFAULT   = 512;
   localparam int WORD_W             = 64;
   localparam int FRAME_W            = 16;

   localparam logic [WORD_W-1:0] ALL_USED = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_MARK  = 2'd2,
      ACT_NOP   = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC_RD,
      ST_ALLOC_CHK,
      ST_UPD_RD,
      ST_UPD_WR
   } state_type;

   typedef enum logic [1:0] {
      ADDR_CLR,
      ADDR_SCAN,
      ADDR_IDX
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_INIT,
      WD_ALLOC,
      WD_FREE,
      WD_MARK
   } wdata_sel_type;

   typedef enum logic [1:0] {
      RSP_ALLOC_OK,
      RSP_FAIL,
      RSP_ECHO
   } rsp_sel_type;

   // controller to datapath
   typedef struct packed {
      logic          capture;
      logic          clr_inc;
      logic          scan_load;
      logic          scan_inc;
      logic          rd_en;
      logic          wr_en;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          hint_from_scan;
      logic          hint_lower;
      logic          rsp_load;
      rsp_sel_type   rsp_sel;
   } fba_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic    clr_last;
      logic    scan_end;
      logic    word_full;
      logic    alloc_ok;
      logic    idx_valid;
      act_type action;
   } fba_stat_type;

   // bit index of a one-hot word, built as an or-tree per index bit
   function automatic logic [5:0] onehot_to_index(input logic [WORD_W-1:0] onehot);
      logic [5:0] idx;
      idx = '0;
      for (int k = 0; k < 6; k++) begin
         for (int i = 0; i < WORD_W; i++) begin
            if (((i >> k) & 1) == 1) begin
               idx[k] = idx[k] | onehot[i];
            end
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== sv/fba_ram.sv =====
// fba_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module fba_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic              wr_en,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/fba_ctrl.sv =====
// fba_ctrl: sequencing state machine of the frame bitmap allocator
// depends on fba_pkg (state, command and status types)
`default_nettype none

module fba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire fba_pkg::fba_stat_type stat,
   output fba_pkg::fba_cmd_type       cmd
);
   import fba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            priority if (stat.action == ACT_ALLOC) begin
               state_in = ST_ALLOC_RD;
            end else if ((stat.action == ACT_FREE || stat.action == ACT_MARK)
                         && stat.idx_valid) begin
               state_in = ST_UPD_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ALLOC_RD: begin
            state_in = stat.scan_end ? ST_IDLE : ST_ALLOC_CHK;
         end
         ST_ALLOC_CHK: begin
            state_in = stat.word_full ? ST_ALLOC_RD : ST_IDLE;
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en     = 1'b1;
            cmd.addr_sel  = ADDR_CLR;
            cmd.wdata_sel = WD_INIT;
            cmd.clr_inc   = 1'b1;
         end
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_DISPATCH: begin
            cmd.scan_load = 1'b1;
            if (!(stat.action == ACT_ALLOC) &&
                !((stat.action == ACT_FREE || stat.action == ACT_MARK) && stat.idx_valid))
            begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_ECHO;
            end
         end
         ST_ALLOC_RD: begin
            cmd.addr_sel = ADDR_SCAN;
            if (stat.scan_end) begin
               cmd.hint_from_scan = 1'b1;
               cmd.rsp_load       = 1'b1;
               cmd.rsp_sel        = RSP_FAIL;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         ST_ALLOC_CHK: begin
            cmd.addr_sel  = ADDR_SCAN;
            cmd.wdata_sel = WD_ALLOC;
            if (stat.word_full) begin
               cmd.scan_inc = 1'b1;
            end else begin
               cmd.hint_from_scan = 1'b1;
               cmd.rsp_load       = 1'b1;
               cmd.wr_en          = stat.alloc_ok;
               cmd.rsp_sel        = stat.alloc_ok ? RSP_ALLOC_OK : RSP_FAIL;
            end
         end
         ST_UPD_RD: begin
            cmd.addr_sel = ADDR_IDX;
            cmd.rd_en    = 1'b1;
         end
         ST_UPD_WR: begin
            cmd.addr_sel   = ADDR_IDX;
            cmd.wr_en      = 1'b1;
            cmd.wdata_sel  = (stat.action == ACT_FREE) ? WD_FREE : WD_MARK;
            cmd.hint_lower = (stat.action == ACT_FREE);
            cmd.rsp_load   = 1'b1;
            cmd.rsp_sel    = RSP_ECHO;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/fba_datapath.sv =====
// fba_datapath: bitmap store, scan pointers, word update and result registers
// depends on fba_pkg and fba_ram
`default_nettype none

module fba_datapath #(
   parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEFAULT,
   parameter int RESERVED   = fba_pkg::RESERVED_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [1:0]                    req_action,
   input  wire logic [fba_pkg::FRAME_W-1:0]   req_frame_index,
   input  wire fba_pkg::fba_cmd_type          cmd,
   output fba_pkg::fba_stat_type              stat,
   output logic                               rsp_valid,
   output logic [fba_pkg::FRAME_W-1:0]        rsp_frame_number,
   output logic                               rsp_status
);
   import fba_pkg::*;

   localparam int WORDS       = (NUM_FRAMES + WORD_W - 1) / WORD_W;
   localparam int AW          = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int HW          = AW + 1;
   localparam int FW          = AW + 6;
   localparam int RES_EFF     = (RESERVED < NUM_FRAMES) ? RESERVED : NUM_FRAMES;
   localparam int RES_WORD    = RES_EFF / WORD_W;
   localparam int RES_BITS    = RES_EFF % WORD_W;
   localparam int ALLOC_LIMIT = (NUM_FRAMES < 65536) ? NUM_FRAMES : 65536;
   localparam logic [WORD_W-1:0] PART_MASK = (64'd1 << RES_BITS) - 64'd1;

   act_type            action_ff;
   logic [FRAME_W-1:0] idx_ff;
   logic [HW-1:0]      clr_ff;
   logic [HW-1:0]      scan_ff;
   logic [HW-1:0]      hint_ff;
   logic               rsp_valid_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic               rsp_status_ff;

   logic [31:0]        idx32;
   logic [AW-1:0]      idx_word;
   logic [WORD_W-1:0]  idx_mask;
   logic [AW-1:0]      ram_addr;
   logic [WORD_W-1:0]  ram_wdata;
   logic [WORD_W-1:0]  ram_rdata;
   logic [WORD_W-1:0]  init_word;
   logic [WORD_W-1:0]  first_zero;
   logic [5:0]         zero_bit;
   logic [FW-1:0]      alloc_frame;
   logic [31:0]        alloc_frame32;

   assign idx32    = {16'd0, idx_ff};
   assign idx_word = idx32[AW+5:6];
   assign idx_mask = 64'd1 << idx_ff[5:0];

   // lowest clear bit of the word just read
   assign first_zero    = ~ram_rdata & (ram_rdata + 64'd1);
   assign zero_bit      = onehot_to_index(first_zero);
   assign alloc_frame   = {scan_ff[AW-1:0], zero_bit};
   assign alloc_frame32 = 32'(alloc_frame);

   // reset image: reserved frames set, the rest clear
   always_comb begin
      priority if (32'(clr_ff) < RES_WORD) begin
         init_word = ALL_USED;
      end else if (32'(clr_ff) == RES_WORD) begin
         init_word = PART_MASK;
      end else begin
         init_word = '0;
      end
   end

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_CLR:  ram_addr = clr_ff[AW-1:0];
         ADDR_SCAN: ram_addr = scan_ff[AW-1:0];
         ADDR_IDX:  ram_addr = idx_word;
         default:   ram_addr = idx_word;
      endcase
   end

   always_comb begin
      unique case (cmd.wdata_sel)
         WD_INIT:  ram_wdata = init_word;
         WD_ALLOC: ram_wdata = ram_rdata | first_zero;
         WD_FREE:  ram_wdata = ram_rdata & ~idx_mask;
         WD_MARK:  ram_wdata = ram_rdata | idx_mask;
         default:  ram_wdata = ram_rdata;
      endcase
   end

   fba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS),
      .ADDR_W(AW)
   ) u_bitmap (
      .clock  (clock),
      .addr   (ram_addr),
      .wr_en  (cmd.wr_en),
      .wr_data(ram_wdata),
      .rd_en  (cmd.rd_en),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= act_type'(req_action);
         idx_ff    <= req_frame_index;
      end
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_sel)
            RSP_ALLOC_OK: begin
               rsp_frame_ff  <= alloc_frame32[FRAME_W-1:0];
               rsp_status_ff <= 1'b0;
            end
            RSP_FAIL: begin
               rsp_frame_ff  <= '0;
               rsp_status_ff <= 1'b1;
            end
            RSP_ECHO: begin
               rsp_frame_ff  <= idx_ff;
               rsp_status_ff <= 1'b0;
            end
            default: begin
               rsp_frame_ff  <= idx_ff;
               rsp_status_ff <= 1'b0;
            end
         endcase
      end
   end

   // words below the hint are all full
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         scan_ff      <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load;
         if (cmd.clr_inc) begin
            clr_ff <= clr_ff + HW'(1);
         end
         priority if (cmd.scan_load) begin
            scan_ff <= hint_ff;
         end else if (cmd.scan_inc) begin
            scan_ff <= scan_ff + HW'(1);
         end
         priority if (cmd.hint_from_scan) begin
            hint_ff <= scan_ff;
         end else if (cmd.hint_lower && ({1'b0, idx_word} < hint_ff)) begin
            hint_ff <= {1'b0, idx_word};
         end
      end
   end

   assign stat.clr_last  = (clr_ff == HW'(WORDS - 1));
   assign stat.scan_end  = (scan_ff >= HW'(WORDS));
   assign stat.word_full = (ram_rdata == ALL_USED);
   assign stat.alloc_ok  = (alloc_frame32 < ALLOC_LIMIT);
   assign stat.idx_valid = (idx32 < NUM_FRAMES);
   assign stat.action    = action_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   a_hint_bound: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= HW'(WORDS))
      else $error("scan hint past end of bitmap");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_frame_ff == '0)
      else $error("exhausted result carries a frame number");
   a_alloc_wr_free: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en && cmd.wdata_sel == WD_ALLOC |-> !stat.word_full && stat.alloc_ok)
      else $error("allocation write on a full word or beyond limit");
`endif

endmodule

`default_nettype wire

// ===== sv/frame_bitmap_allocator.sv =====
// frame_bitmap_allocator: top level, controller plus datapath
// depends on fba_pkg, fba_ctrl, fba_datapath (and fba_ram below it)
`default_nettype none

// page-frame allocator over a bitmap store, one bit per frame, 1 = used
// request beat: start with req_action and req_frame_index, taken when busy is low
//   allocate returns the lowest free frame and marks it used
//   free / mark clear / set the bit of req_frame_index and echo it
// response beat: rsp_valid high for one cycle with rsp_frame_number and rsp_status
//   the receiver cannot stall, every response is taken in its cycle
// steps from acceptance to the registered response:
//   free and mark of a frame in range: read word, write back
//   unused action or frame out of range: answered from dispatch
//   allocate: words are read and checked from the hint on until one is not full;
//   a hint register keeps the lowest word that may hold a free frame, so only
//   words filled since the last free are walked, one single-port ram read each
//   exhausted allocate with the hint at the end: fails without a ram read
// one request is in flight at a time; busy drops again when its response leaves
// reset: a clearing pass writes every bitmap word once, loading the reserved
//   frames as used; busy stays high until the pass is done

module frame_bitmap_allocator #(
   parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEFAULT,
   parameter int RESERVED   = fba_pkg::RESERVED_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_action,
   input  wire logic [fba_pkg::FRAME_W-1:0] req_frame_index,
   output logic                             rsp_valid,
   output logic [fba_pkg::FRAME_W-1:0]      rsp_frame_number,
   output logic                             rsp_status
);
   import fba_pkg::*;

   fba_cmd_type  cmd;
   fba_stat_type stat;

   // sequencing: clear pass, dispatch, word scan, read-modify-write
   fba_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   // bitmap ram, pointers and response registers
   fba_datapath #(
      .NUM_FRAMES(NUM_FRAMES),
      .RESERVED  (RESERVED)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_frame_index (req_frame_index),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_frame_number(rsp_frame_number),
      .rsp_status      (rsp_status)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not occupy the block");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire
